// ----- src/ihgb_pkg.sv -----
// Shared types and constants of the Irwin-Hall Gaussian binner.
package ihgb_pkg;

  localparam int unsigned NUM_BINS_DEF  = 21;
  localparam int unsigned SUM_TERMS_DEF = 12;

  localparam int unsigned SEED_W    = 32;
  localparam int unsigned VAL_W     = 36;
  localparam int unsigned BW_W      = 35;
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned CFG_AW    = 2;

  localparam logic [SEED_W-1:0] DEFAULT_SEED = 32'h854329A5;

  localparam logic [CFG_AW-1:0] CFG_SEED      = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_RANGE_MIN = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_RANGE_MAX = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_BIN_WIDTH = 2'd3;

  localparam logic [VAL_W-1:0] RANGE_MIN_RST = 36'hA00000000;
  localparam logic [VAL_W-1:0] RANGE_MAX_RST = 36'h600000000;
  localparam logic [BW_W-1:0]  BIN_WIDTH_RST = 35'd2454267026;

  typedef struct packed {
    logic start;
    logic gen;
    logic sat;
    logic cmp;
    logic div;
    logic mul;
    logic ctr;
    logic out_load;
  } cmd_t;

endpackage

// ----- src/irwin_hall_gaussian_binner_core.sv -----
// Top level of the Irwin-Hall Gaussian binner.
// Each accepted word runs through the one-step-per-cycle generator sweep and the
// restoring bin divider. A new word is accepted only while the sequencer is idle;
// a finished word waits in the output register while the next one runs, and that
// next word holds before its own output load until the output register is free.
// Reset (synchronous, rst_n low) restores register defaults and the generator seed.
module irwin_hall_gaussian_binner_core #(
  parameter int unsigned NUM_BINS  = ihgb_pkg::NUM_BINS_DEF,
  parameter int unsigned SUM_TERMS = ihgb_pkg::SUM_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ihgb_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [ihgb_pkg::VAL_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ihgb_pkg::VAL_W-1:0]     out_sample,
  output logic [ihgb_pkg::IDX_OUT_W-1:0] out_bin_slot,
  output logic [ihgb_pkg::VAL_W-1:0]     out_bin_center
);

  ihgb_pkg::cmd_t cmd;

  ihgb_ctrl #(
    .NUM_BINS (NUM_BINS),
    .SUM_TERMS(SUM_TERMS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  ihgb_dp #(
    .NUM_BINS (NUM_BINS),
    .SUM_TERMS(SUM_TERMS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_restart    (in_restart),
    .cmd           (cmd),
    .out_sample    (out_sample),
    .out_bin_slot  (out_bin_slot),
    .out_bin_center(out_bin_center)
  );

endmodule

// ----- src/ihgb_ctrl.sv -----
// Sequencer that steps the binner datapath through one word.
module ihgb_ctrl #(
  parameter int unsigned NUM_BINS  = ihgb_pkg::NUM_BINS_DEF,
  parameter int unsigned SUM_TERMS = ihgb_pkg::SUM_TERMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ihgb_pkg::cmd_t cmd
);

  localparam int unsigned IW   = $clog2(NUM_BINS);
  localparam int unsigned MAXC = (SUM_TERMS > IW + 1) ? SUM_TERMS : IW + 1;
  localparam int unsigned CW   = $clog2(MAXC);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_GEN  = 8'b00000010,
    S_SAT  = 8'b00000100,
    S_CMP  = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_MUL  = 8'b00100000,
    S_CTR  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = CW'(SUM_TERMS - 1);
          state_nxt = S_GEN;
        end
      end
      S_GEN: begin
        cmd.gen = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SAT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        cnt_nxt   = CW'(IW);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CTR;
      end
      S_CTR: begin
        cmd.ctr   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_start_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_GEN && cnt_r == CW'(SUM_TERMS - 1)))
    else $error("accepted word did not start the generator sweep");

  a_gen_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN) |-> (cnt_r <= CW'(SUM_TERMS - 1)))
    else $error("generator step count out of range");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CW'(IW)))
    else $error("divider step count out of range");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("finished word was not presented");

endmodule

// ----- src/ihgb_dp.sv -----
// Datapath of the binner: configuration, generator, accumulator, divider and center.
module ihgb_dp #(
  parameter int unsigned NUM_BINS  = ihgb_pkg::NUM_BINS_DEF,
  parameter int unsigned SUM_TERMS = ihgb_pkg::SUM_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ihgb_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [ihgb_pkg::VAL_W-1:0]     cfg_wdata,
  input  logic                           in_restart,
  input  ihgb_pkg::cmd_t                 cmd,
  output logic [ihgb_pkg::VAL_W-1:0]     out_sample,
  output logic [ihgb_pkg::IDX_OUT_W-1:0] out_bin_slot,
  output logic [ihgb_pkg::VAL_W-1:0]     out_bin_center
);

  localparam int unsigned VW  = ihgb_pkg::VAL_W;
  localparam int unsigned BW  = ihgb_pkg::BW_W;
  localparam int unsigned GW  = ihgb_pkg::SEED_W;
  localparam int unsigned IW  = $clog2(NUM_BINS);
  localparam int unsigned QW  = IW + 1;
  localparam int unsigned DVW = BW + IW;
  localparam int unsigned SW  = GW + $clog2(SUM_TERMS + 1);
  localparam int unsigned EW  = (SW + 1 > VW + 1) ? SW + 1 : VW + 1;
  localparam int unsigned PW  = QW + BW;
  localparam int unsigned TW  = PW + 2;
  localparam int unsigned HW  = TW - 1;

  localparam logic [EW-1:0] OFFSET = EW'(64'(SUM_TERMS) << 31);
  localparam logic [VW-1:0] POS_SAT = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] NEG_SAT = {1'b1, {(VW-1){1'b0}}};

  function automatic logic [GW-1:0] advance(input logic [GW-1:0] x);
    logic [GW-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  logic [GW-1:0]  seed_r;
  logic [VW-1:0]  lo_r, hi_r;
  logic [BW-1:0]  bw_r;
  logic [GW-1:0]  gen_r, gen_nxt;
  logic [SW-1:0]  sum_r;
  logic [VW-1:0]  sample_r;
  logic           below_r, above_r;
  logic [VW-1:0]  rem_r;
  logic [DVW-1:0] dvs_r;
  logic [QW-1:0]  q_r;
  logic [IW-1:0]  idx_r;
  logic [PW-1:0]  prod_r;
  logic [VW-1:0]  ctr_r;

  logic [EW-1:0]  smp_wide;
  logic           smp_fits;
  logic [VW-1:0]  smp_sat;
  logic [VW:0]    diff;
  logic [DVW-1:0] rem_ext;
  logic           ge;
  logic [IW-1:0]  idx_sel;
  logic [TW-1:0]  tot;
  logic [HW-1:0]  half;
  logic           ctr_fits;
  logic [VW-1:0]  ctr_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      lo_r   <= ihgb_pkg::RANGE_MIN_RST;
      hi_r   <= ihgb_pkg::RANGE_MAX_RST;
      bw_r   <= ihgb_pkg::BIN_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ihgb_pkg::CFG_SEED:      seed_r <= cfg_wdata[GW-1:0];
        ihgb_pkg::CFG_RANGE_MIN: lo_r   <= cfg_wdata;
        ihgb_pkg::CFG_RANGE_MAX: hi_r   <= cfg_wdata;
        ihgb_pkg::CFG_BIN_WIDTH: bw_r   <= cfg_wdata[BW-1:0];
        default: ;
      endcase
    end
  end

  assign gen_nxt = advance(gen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= ihgb_pkg::DEFAULT_SEED;
    end else if (cmd.start && in_restart) begin
      gen_r <= (seed_r != '0) ? seed_r : ihgb_pkg::DEFAULT_SEED;
    end else if (cmd.gen) begin
      gen_r <= gen_nxt;
    end
  end

  assign smp_wide = EW'(sum_r) - OFFSET;
  assign smp_fits = (&smp_wide[EW-1:VW-1]) || !(|smp_wide[EW-1:VW-1]);
  assign smp_sat  = smp_fits ? smp_wide[VW-1:0] : (smp_wide[EW-1] ? NEG_SAT : POS_SAT);

  assign diff    = {sample_r[VW-1], sample_r} - {lo_r[VW-1], lo_r};
  assign rem_ext = DVW'(rem_r);
  assign ge      = rem_ext >= dvs_r;

  always_comb begin
    if (below_r) begin
      idx_sel = '0;
    end else if (above_r || q_r >= QW'(NUM_BINS)) begin
      idx_sel = IW'(NUM_BINS - 1);
    end else begin
      idx_sel = q_r[IW-1:0];
    end
  end

  assign tot      = {{(TW-VW-1){lo_r[VW-1]}}, lo_r, 1'b0} + {2'b00, prod_r};
  assign half     = tot[TW-1:1];
  assign ctr_fits = (&half[HW-1:VW-1]) || !(|half[HW-1:VW-1]);
  assign ctr_sat  = ctr_fits ? half[VW-1:0] : (half[HW-1] ? NEG_SAT : POS_SAT);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum_r <= '0;
    end else if (cmd.gen) begin
      sum_r <= sum_r + SW'(gen_nxt);
    end
    if (cmd.sat) begin
      sample_r <= smp_sat;
    end
    if (cmd.cmp) begin
      below_r <= $signed(sample_r) < $signed(lo_r);
      above_r <= $signed(sample_r) >= $signed(hi_r);
      rem_r   <= diff[VW-1:0];
      dvs_r   <= {bw_r, {IW{1'b0}}};
      q_r     <= '0;
    end else if (cmd.div) begin
      if (ge) begin
        rem_r <= VW'(rem_ext - dvs_r);
      end
      q_r   <= {q_r[QW-2:0], ge};
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.mul) begin
      idx_r  <= idx_sel;
      prod_r <= PW'({idx_sel, 1'b1}) * PW'(bw_r);
    end
    if (cmd.ctr) begin
      ctr_r <= ctr_sat;
    end
    if (cmd.out_load) begin
      out_sample     <= sample_r;
      out_bin_slot   <= ihgb_pkg::IDX_OUT_W'(idx_r);
      out_bin_center <= ctr_r;
    end
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the Irwin-Hall Gaussian binner core.
`timescale 1ns / 100ps

module tb;

  localparam int BINS  = ihgb_pkg::NUM_BINS_DEF;
  localparam int TERMS = ihgb_pkg::SUM_TERMS_DEF;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 16;
  localparam int DRAWS_PER_PHASE = 120;

  localparam logic [ihgb_pkg::VAL_W-1:0] Q_MIN  = 36'h8_0000_0000;
  localparam logic [ihgb_pkg::VAL_W-1:0] Q_MAX  = 36'h7_FFFF_FFFF;
  localparam logic [ihgb_pkg::VAL_W-1:0] Q_POS3 = 36'h3_0000_0000;
  localparam logic [ihgb_pkg::VAL_W-1:0] Q_NEG3 = 36'hD_0000_0000;
  localparam logic [ihgb_pkg::VAL_W-1:0] Q_POS5 = 36'h5_0000_0000;
  localparam logic [ihgb_pkg::VAL_W-1:0] Q_NEG5 = 36'hB_0000_0000;
  localparam logic [ihgb_pkg::VAL_W-1:0] Q_WDEF = {1'b0, ihgb_pkg::BIN_WIDTH_RST};
  localparam longint S36_MAX = (longint'(1) <<< 35) - 1;
  localparam longint S36_MIN = -(longint'(1) <<< 35);

  typedef struct packed {
    logic [ihgb_pkg::VAL_W-1:0]     sample;
    logic [ihgb_pkg::IDX_OUT_W-1:0] bin_slot;
    logic [ihgb_pkg::VAL_W-1:0]     bin_center;
  } deviate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ihgb_pkg::CFG_AW-1:0] cfg_index = ihgb_pkg::CFG_SEED;
  logic [ihgb_pkg::VAL_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ihgb_pkg::VAL_W-1:0] out_sample;
  logic [ihgb_pkg::IDX_OUT_W-1:0] out_bin_slot;
  logic [ihgb_pkg::VAL_W-1:0] out_bin_center;

  // Local copy of the block's registers and generator state.
  logic [ihgb_pkg::SEED_W-1:0] seed_reg = '0;
  logic [ihgb_pkg::VAL_W-1:0] rmin_reg = ihgb_pkg::RANGE_MIN_RST;
  logic [ihgb_pkg::VAL_W-1:0] rmax_reg = ihgb_pkg::RANGE_MAX_RST;
  logic [ihgb_pkg::BW_W-1:0] bw_reg = ihgb_pkg::BIN_WIDTH_RST;
  logic [ihgb_pkg::SEED_W-1:0] gen_state = ihgb_pkg::DEFAULT_SEED;

  logic draw_requests[$];
  deviate_t expected_q[$];
  deviate_t head_word;
  int send_idle = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int draws_accepted = 0;
  int words_checked = 0;

  irwin_hall_gaussian_binner_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample),
    .out_bin_slot(out_bin_slot),
    .out_bin_center(out_bin_center)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clip36(input longint v);
    if (v > S36_MAX) return S36_MAX;
    if (v < S36_MIN) return S36_MIN;
    return v;
  endfunction

  function automatic deviate_t draw_deviate(input logic restart);
    logic [31:0] x;
    longint acc, smp, lo, hi, ctr, quo;
    int bin;
    int k;
    deviate_t d;
    if (restart) gen_state = (seed_reg != '0) ? seed_reg : ihgb_pkg::DEFAULT_SEED;
    acc = 0;
    for (k = 0; k < TERMS; k++) begin
      x = gen_state;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      gen_state = x;
      acc += longint'(x);
    end
    smp = clip36(acc - (longint'(TERMS) <<< 31));
    lo = longint'($signed(rmin_reg));
    hi = longint'($signed(rmax_reg));
    if (smp < lo) begin
      bin = 0;
    end else if (smp >= hi || bw_reg == '0) begin
      bin = BINS - 1;
    end else begin
      quo = (smp - lo) / longint'(bw_reg);
      bin = (quo >= BINS) ? BINS - 1 : int'(quo);
    end
    ctr = clip36((2 * lo + longint'(2 * bin + 1) * longint'(bw_reg)) >>> 1);
    d.sample = smp[ihgb_pkg::VAL_W-1:0];
    d.bin_slot = bin[ihgb_pkg::IDX_OUT_W-1:0];
    d.bin_center = ctr[ihgb_pkg::VAL_W-1:0];
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t word %0d: %s", $realtime, words_checked, msg);
    mismatches++;
  endtask

  // Registers are only rewritten while nothing is in flight.
  task automatic apply_setting(input logic [ihgb_pkg::SEED_W-1:0] s,
                               input logic [ihgb_pkg::VAL_W-1:0] lo,
                               input logic [ihgb_pkg::VAL_W-1:0] hi,
                               input logic [ihgb_pkg::VAL_W-1:0] bw);
    logic [ihgb_pkg::CFG_AW-1:0] regs [4];
    logic [ihgb_pkg::VAL_W-1:0] vals [4];
    int k;
    regs = '{ihgb_pkg::CFG_SEED, ihgb_pkg::CFG_RANGE_MIN, ihgb_pkg::CFG_RANGE_MAX,
             ihgb_pkg::CFG_BIN_WIDTH};
    vals = '{{4'd0, s}, lo, hi, bw};
    for (k = 0; k < 4; k++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_reg = s;
    rmin_reg = lo;
    rmax_reg = hi;
    bw_reg = bw[ihgb_pkg::BW_W-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (draw_requests.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(draw_deviate(in_restart));
        draws_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (draw_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_restart <= draw_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with no draw outstanding");
        end else begin
          head_word = expected_q.pop_front();
          if (out_sample !== head_word.sample)
            report_mismatch($sformatf("sample %h, expected %h", out_sample, head_word.sample));
          if (out_bin_slot !== head_word.bin_slot)
            report_mismatch($sformatf("bin slot %0d, expected %0d",
                                      out_bin_slot, head_word.bin_slot));
          if (out_bin_center !== head_word.bin_center)
            report_mismatch($sformatf("bin_center %h, expected %h",
                                      out_bin_center, head_word.bin_center));
        end
        words_checked++;
      end
    end
  end

  initial begin
    longint lo_v, span_v;
    logic [ihgb_pkg::SEED_W-1:0] s_v;
    logic [ihgb_pkg::VAL_W-1:0] lo_r, hi_r, bw_r;
    int ph, n;
    int idle_send [4];
    int idle_recv [4];
    idle_send = '{0, 60, 0, 9};
    idle_recv = '{0, 0, 60, 9};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset registers, including a restart from the zero seed.
    draw_requests = '{1'b0, 1'b1, 1'b0};
    wait_idle();
    // Full range with the narrowest bin: the quotient always overflows.
    apply_setting(32'hFFFF_FFFF, Q_MIN, Q_MAX, 36'd1);
    draw_requests = '{1'b1, 1'b0};
    wait_idle();
    // Empty range at the bottom with the widest bin: center saturates high.
    apply_setting(32'h0000_0001, Q_MIN, Q_MIN, 36'hF_FFFF_FFFF);
    draw_requests = '{1'b1, 1'b0};
    wait_idle();
    // Range above nearly every sample.
    apply_setting(32'h8000_0000, Q_POS5, ihgb_pkg::RANGE_MAX_RST, Q_WDEF);
    draw_requests = '{1'b1, 1'b0};
    wait_idle();
    // Range below nearly every sample, reloaded from a zero seed.
    apply_setting(32'h0000_0000, ihgb_pkg::RANGE_MIN_RST, Q_NEG5, Q_WDEF);
    draw_requests = '{1'b1, 1'b0};
    wait_idle();
    // Inverted range.
    apply_setting(32'h1234_5678, Q_POS3, Q_NEG3, Q_WDEF);
    draw_requests = '{1'b1, 1'b0, 1'b0};
    wait_idle();
    // Zero bin width.
    apply_setting(32'hDEAD_BEEF, ihgb_pkg::RANGE_MIN_RST, ihgb_pkg::RANGE_MAX_RST, 36'd0);
    draw_requests = '{1'b0, 1'b1};
    wait_idle();
    // Range starting at zero and reaching the top.
    apply_setting(32'h7FFF_FFFF, 36'd0, Q_MAX, 36'h0_4000_0000);
    draw_requests = '{1'b0, 1'b0};
    wait_idle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      s_v = ($urandom_range(7) == 0) ? '0 : $urandom;
      if ($urandom_range(3) == 0) begin
        lo_r = {4'($urandom), $urandom};
        hi_r = {4'($urandom), $urandom};
        bw_r = {4'($urandom), $urandom};
      end else begin
        lo_v = -(longint'($urandom_range(8 * 1024, 256)) <<< 22);
        span_v = longint'($urandom_range(8 * 1024, 256)) <<< 22;
        lo_r = lo_v[ihgb_pkg::VAL_W-1:0];
        hi_r = 36'(lo_v + span_v);
        bw_r = 36'(span_v / BINS + longint'($urandom_range(4096)));
      end
      apply_setting(s_v, lo_r, hi_r, bw_r);
      send_idle = idle_send[ph % 4];
      recv_stall = idle_recv[ph % 4];
      for (n = 0; n < DRAWS_PER_PHASE; n++)
        draw_requests.push_back($urandom_range(11) == 0);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Timeout with %0d words outstanding", expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
